// ===== rtl/htbd_pkg.sv =====
// Shared types and constants for the Huffman tree bit decoder.
package htbd_pkg;

  localparam int NODE_COUNT  = 512;
  localparam int SYMBOL_BITS = 8;
  localparam int MEM_AW      = $clog2(NODE_COUNT);

  localparam int IDX_W  = 9;
  localparam int SYM_W  = 8;
  localparam int LEN_W  = 8;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  localparam int APB_AW = 3;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_DECODE = 1'b1
  } htbd_op_e;

  typedef enum logic {
    REG_ROOT_INDEX = 1'b0,
    REG_NONE       = 1'b1
  } htbd_reg_e;

  typedef logic [IDX_W-1:0] htbd_idx_t;

  typedef struct packed {
    htbd_op_e         opcode;
    htbd_idx_t        node_addr;
    htbd_idx_t        node_left;
    htbd_idx_t        node_right;
    logic             node_is_leaf;
    logic [SYM_W-1:0] node_symbol;
    logic             code_bit;
  } htbd_in_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic [LEN_W-1:0] code_length;
  } htbd_out_t;

  typedef struct packed {
    htbd_idx_t              left;
    htbd_idx_t              right;
    logic                   leaf;
    logic [SYMBOL_BITS-1:0] sym;
  } htbd_node_t;

  // True when a node index lies inside the table.
  function automatic logic idx_in_range(htbd_idx_t idx);
    return 32'(idx) < NODE_COUNT;
  endfunction

endpackage

// ===== rtl/huffman_tree_bit_decoder_core.sv =====
// Top level: Huffman tree bit decoder with APB configuration port.
// A node write leaves busy low, so writes go at one per cycle while no decode walk is busy.
// A decode bit reads the current node, then the chosen child: busy is high in ST_START and
// ST_NEXT, the next decode bit waits for idle, and a leaf child's symbol is registered in ST_NEXT.
// A root that is a leaf settles the bit on the first read: its result is registered from ST_START.
// Reset clears the walk and root_index; the node memory is not cleared. No output stall.
module huffman_tree_bit_decoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  htbd_pkg::htbd_in_t            item_i,
  output logic                          res_valid_o,
  output htbd_pkg::htbd_out_t           res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [htbd_pkg::APB_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import htbd_pkg::*;

  htbd_idx_t root_q;
  htbd_reg_e reg_sel;
  logic      cfg_wr;
  logic      accept;

  // Word select; the byte offset bits do not matter.
  assign reg_sel = htbd_reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_wr && (reg_sel == REG_ROOT_INDEX)) begin
      root_q <= pwdata[IDX_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ROOT_INDEX: prdata = {{(32-IDX_W){1'b0}}, root_q};
      default:        prdata = '0;
    endcase
  end

  assign accept = start && !busy;

  htbd_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (item_i),
    .root_i      (root_q),
    .busy_o      (busy),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // A result only follows a walk that was in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy))
    else $error("result without a walk in progress");

  // Every emitted code is at least one bit long.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.code_length != '0))
    else $error("zero code length emitted");

  // A node write never causes a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (item_i.opcode == OP_WRITE)) |=> !res_valid_o)
    else $error("result after a node write");

  // The walk starts only from an accepted decode bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(accept && (item_i.opcode == OP_DECODE)))
    else $error("walk started without a decode transfer");

  // A walk never stays busy beyond its ST_START and ST_NEXT states.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && $past(busy)) |=> !busy)
    else $error("walk exceeded two cycles");

endmodule

// ===== rtl/htbd_walk.sv =====
// Node table memory and the tree-walk sequencer.
module htbd_walk (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  htbd_pkg::htbd_in_t item_i,
  input  htbd_pkg::htbd_idx_t root_i,
  output logic               busy_o,
  output logic               res_valid_o,
  output htbd_pkg::htbd_out_t res_o
);
  import htbd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_NEXT
  } state_e;

  htbd_node_t mem [NODE_COUNT];

  state_e           state_q;
  htbd_idx_t        cur_q;
  logic             at_root_q;
  logic [LEN_W-1:0] bits_q;
  logic             bit_q;
  logic             was_root_q;
  logic [LEN_W-1:0] count_q;
  htbd_idx_t        next_q;
  logic             rd_ok_q;
  htbd_node_t       rd_data_q;
  logic             res_valid_q;
  htbd_out_t        res_q;

  htbd_node_t entry;
  htbd_idx_t  child;
  htbd_idx_t  rd_idx;
  logic       rd_en;
  logic       wr_en;
  logic       dec_accept;
  htbd_node_t wr_node;

  assign dec_accept = accept_i && (item_i.opcode == OP_DECODE);
  assign wr_en      = accept_i && (item_i.opcode == OP_WRITE) && idx_in_range(item_i.node_addr);

  assign wr_node.left  = item_i.node_left;
  assign wr_node.right = item_i.node_right;
  assign wr_node.leaf  = item_i.node_is_leaf;
  assign wr_node.sym   = SYMBOL_BITS'(item_i.node_symbol);

  // Indices outside the table read as an empty inner node.
  assign entry = rd_ok_q ? rd_data_q : '0;
  assign child = bit_q ? entry.right : entry.left;

  assign rd_idx = (state_q == ST_IDLE) ? (at_root_q ? root_i : cur_q) : child;
  assign rd_en  = dec_accept || (state_q == ST_START);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[MEM_AW'(item_i.node_addr)] <= wr_node;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[MEM_AW'(rd_idx)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      at_root_q   <= 1'b1;
      bits_q      <= '0;
      bit_q       <= 1'b0;
      was_root_q  <= 1'b0;
      count_q     <= '0;
      next_q      <= '0;
      rd_ok_q     <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (dec_accept) begin
            bit_q      <= item_i.code_bit;
            was_root_q <= at_root_q;
            rd_ok_q    <= idx_in_range(rd_idx);
            if (at_root_q) begin
              count_q <= LEN_W'(1);
            end else if (bits_q == LEN_MAX) begin
              count_q <= LEN_MAX;
            end else begin
              count_q <= bits_q + LEN_W'(1);
            end
            state_q <= ST_START;
          end
        end
        ST_START: begin
          if (was_root_q && entry.leaf) begin
            // Single-symbol tree: the root itself answers every bit.
            res_valid_q       <= 1'b1;
            res_q.symbol      <= SYM_W'(entry.sym);
            res_q.code_length <= LEN_W'(1);
            at_root_q         <= 1'b1;
            bits_q            <= '0;
            state_q           <= ST_IDLE;
          end else begin
            next_q  <= child;
            rd_ok_q <= idx_in_range(child);
            state_q <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (entry.leaf) begin
            res_valid_q       <= 1'b1;
            res_q.symbol      <= SYM_W'(entry.sym);
            res_q.code_length <= count_q;
            at_root_q         <= 1'b1;
            bits_q            <= '0;
            cur_q             <= '0;
          end else begin
            cur_q     <= next_q;
            at_root_q <= 1'b0;
            bits_q    <= count_q;
          end
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
